FILE: rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants of the semigroup child generator
// Entry codes, request kinds, status codes, widths and the sequencer states.
// ----------------------------------------------------------------------------
package nsc_pkg;

   localparam int TABLE_SIZE = 64;
   localparam int MAX_EMIT   = 64;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = IDX_W + 1;
   localparam int EMIT_LIMIT = (TABLE_SIZE < MAX_EMIT) ? TABLE_SIZE : MAX_EMIT;

   typedef logic [1:0] nsc_entry_type;

   localparam nsc_entry_type ENT_GAP = 2'd0;
   localparam nsc_entry_type ENT_IRR = 2'd1;
   localparam nsc_entry_type ENT_DEC = 2'd2;
   localparam nsc_entry_type ENT_ILL = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_GEN  = 1'b1;

   typedef logic [1:0] nsc_status_type;

   localparam nsc_status_type STATUS_OK       = 2'd0;
   localparam nsc_status_type STATUS_BAD_GEN  = 2'd1;
   localparam nsc_status_type STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     addr;
      nsc_entry_type        data;
   } nsc_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ERR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_GAP,
      ST_PAR_RD,
      ST_PAR_CHK,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT
   } nsc_state_type;

endpackage

FILE: rtl/nsc_req_if.sv
// ----------------------------------------------------------------------------
// nsc_req_if: request channel of the semigroup child generator
// Valid/ready handshake carrying a load or a generate request.
// ----------------------------------------------------------------------------
interface nsc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [nsc_pkg::IDX_W-1:0] table_index;
   logic [1:0]                entry_value;
   logic [nsc_pkg::IDX_W-1:0] parent_conductor;
   logic [nsc_pkg::IDX_W-1:0] parent_multiplicity;
   logic [nsc_pkg::IDX_W-1:0] generator;

   modport source (
      output valid, kind, table_index, entry_value,
             parent_conductor, parent_multiplicity, generator,
      input  ready
   );

   modport sink (
      input  valid, kind, table_index, entry_value,
             parent_conductor, parent_multiplicity, generator,
      output ready
   );
endinterface

FILE: rtl/nsc_rsp_if.sv
// ----------------------------------------------------------------------------
// nsc_rsp_if: result channel of the semigroup child generator
// Valid/ready handshake carrying one child table entry or an error.
// ----------------------------------------------------------------------------
interface nsc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nsc_pkg::IDX_W-1:0] out_index;
   logic [1:0]                out_value;
   logic                      last_entry;
   logic [nsc_pkg::CNT_W-1:0] child_conductor;
   logic [nsc_pkg::CNT_W-1:0] child_multiplicity;
   logic [nsc_pkg::CNT_W-1:0] child_children;
   logic [1:0]                status;

   modport source (
      output valid, out_index, out_value, last_entry, child_conductor,
             child_multiplicity, child_children, status,
      input  ready
   );

   modport sink (
      input  valid, out_index, out_value, last_entry, child_conductor,
             child_multiplicity, child_children, status,
      output ready
   );
endinterface

FILE: rtl/nsc_child_mem.sv
// ----------------------------------------------------------------------------
// nsc_child_mem: child table storage
// One write port and two synchronous read ports with registered data, so a
// pair of entries can be probed every cycle.
// ----------------------------------------------------------------------------
module nsc_child_mem (
   input  logic                       clock,
   input  nsc_pkg::nsc_wr_type        wr,
   input  logic [nsc_pkg::IDX_W-1:0]  addr_a,
   input  logic [nsc_pkg::IDX_W-1:0]  addr_b,
   output nsc_pkg::nsc_entry_type     rd_a,
   output nsc_pkg::nsc_entry_type     rd_b
);

   nsc_pkg::nsc_entry_type mem [nsc_pkg::TABLE_SIZE];
   nsc_pkg::nsc_entry_type rd_a_ff;
   nsc_pkg::nsc_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

FILE: rtl/numerical_semigroup_child.sv
// ----------------------------------------------------------------------------
// numerical_semigroup_child: builds one child of a numerical semigroup
// Loads fill the parent table; a generate request removes one generator and
// streams the child table out, entry by entry.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries
//   req      in         load of one parent entry, or generate request
//   rsp      out        one child entry per result, or a single error
//
// A load writes the parent table from the idle state. A generate request
// checks the generator x, copies the entries below x, writes the gap at x,
// copies each later entry i the parent marks irreducible, probes up to i
// pairs for any other and then emits each child entry. The probe loop is
// bound by the child memory's two read ports: one pair of entries per cycle.
// An invalid generator or an oversized child ends in a single error result.
// Reset clears the sequencer and the result valid flag only; the tables
// need no clearing pass. A stalled result holds the sequencer in its emit or
// error state; loads are accepted while the last result waits.
// ----------------------------------------------------------------------------
module numerical_semigroup_child (
   input logic       clock,
   input logic       reset,
   nsc_req_if.sink   req,
   nsc_rsp_if.source rsp
);

   localparam int IW = nsc_pkg::IDX_W;
   localparam int CW = nsc_pkg::CNT_W;
   localparam logic [CW-1:0]  TSIZE  = CW'(nsc_pkg::TABLE_SIZE);
   localparam logic [CW:0]    ELIMIT = (CW + 1)'(nsc_pkg::EMIT_LIMIT);

   nsc_pkg::nsc_state_type state_ff, state_in;

   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] j_ff, j_in;
   logic          issue_done_ff, issue_done_in;
   logic          probe_vld_ff, probe_vld_in;
   logic          probe_last_ff, probe_last_in;

   logic [IW-1:0] gen_ff, gen_in;
   logic [IW-1:0] pc_ff, pc_in;
   logic [IW-1:0] pm_ff, pm_in;
   logic [CW-1:0] psize_ff, psize_in;
   logic [CW-1:0] cc_ff, cc_in;
   logic [CW-1:0] cm_ff, cm_in;
   logic [CW-1:0] csize_ff, csize_in;
   logic [CW-1:0] children_ff, children_in;
   nsc_pkg::nsc_status_type err_ff, err_in;

   // parent table
   nsc_pkg::nsc_entry_type par_mem [nsc_pkg::TABLE_SIZE];
   nsc_pkg::nsc_entry_type par_rdata_ff;
   logic                   par_we;
   nsc_pkg::nsc_entry_type par_wdata;
   logic [IW-1:0]          par_raddr;

   // child table
   nsc_pkg::nsc_wr_type    chd_wr;
   logic [IW-1:0]          chd_addr_a, chd_addr_b;
   nsc_pkg::nsc_entry_type chd_rd_a, chd_rd_b;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic                    rsp_free;
   logic [IW-1:0]           rsp_index_ff, rsp_index_in;
   nsc_pkg::nsc_entry_type  rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CW-1:0]           rsp_cc_ff, rsp_cc_in;
   logic [CW-1:0]           rsp_cm_ff, rsp_cm_in;
   logic [CW-1:0]           rsp_ch_ff, rsp_ch_in;
   nsc_pkg::nsc_status_type rsp_status_ff, rsp_status_in;

   logic [CW-1:0]          idx_ext, idx_inc, gen_ext;
   logic                   adv_last;
   nsc_pkg::nsc_entry_type par_val;
   logic                   gen_bad;
   logic [CW-1:0]          cc_calc, cm_calc;
   logic [CW:0]            csize_calc;
   logic                   hit;

   nsc_child_mem u_chd (
      .clock  (clock),
      .wr     (chd_wr),
      .addr_a (chd_addr_a),
      .addr_b (chd_addr_b),
      .rd_a   (chd_rd_a),
      .rd_b   (chd_rd_b)
   );

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[req.table_index] <= par_wdata;
      end
      par_rdata_ff <= par_mem[par_raddr];
   end

   assign idx_ext  = {1'b0, idx_ff};
   assign idx_inc  = idx_ext + CW'(1);
   assign gen_ext  = {1'b0, gen_ff};
   assign adv_last = (idx_inc == csize_ff);

   // Entries at or past the parent size read as decomposable.
   assign par_val  = (idx_ext >= psize_ff) ? nsc_pkg::ENT_DEC : par_rdata_ff;
   assign gen_bad  = (gen_ff == '0) || (gen_ff < pc_ff) || (gen_ext >= TSIZE)
                  || (gen_ext >= psize_ff) || (par_rdata_ff != nsc_pkg::ENT_IRR);
   assign cc_calc    = gen_ext + CW'(1);
   assign cm_calc    = (gen_ff == pm_ff) ? ({1'b0, pm_ff} + CW'(1)) : {1'b0, pm_ff};
   assign csize_calc = {1'b0, cc_calc} + {1'b0, cm_calc};
   assign hit        = (chd_rd_a == nsc_pkg::ENT_IRR) && (chd_rd_b != nsc_pkg::ENT_GAP);

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      issue_done_in = issue_done_ff;
      probe_vld_in  = 1'b0;
      probe_last_in = probe_last_ff;
      gen_in        = gen_ff;
      pc_in         = pc_ff;
      pm_in         = pm_ff;
      psize_in      = psize_ff;
      cc_in         = cc_ff;
      cm_in         = cm_ff;
      csize_in      = csize_ff;
      children_in   = children_ff;
      err_in        = err_ff;

      req.ready     = 1'b0;
      par_we        = 1'b0;
      par_wdata     = (req.entry_value == nsc_pkg::ENT_ILL) ? nsc_pkg::ENT_DEC
                                                            : req.entry_value;
      par_raddr     = idx_ff;

      chd_wr.en     = 1'b0;
      chd_wr.addr   = idx_ff;
      chd_wr.data   = nsc_pkg::ENT_GAP;
      chd_addr_a    = idx_ff;
      chd_addr_b    = idx_ff;

      rsp_load      = 1'b0;
      rsp_index_in  = '0;
      rsp_value_in  = nsc_pkg::ENT_GAP;
      rsp_last_in   = 1'b0;
      rsp_cc_in     = '0;
      rsp_cm_in     = '0;
      rsp_ch_in     = '0;
      rsp_status_in = nsc_pkg::STATUS_OK;

      case (state_ff)
         nsc_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            par_raddr = req.generator;
            if (req.valid) begin
               if (req.kind == nsc_pkg::KIND_LOAD) begin
                  par_we = ({1'b0, req.table_index} < TSIZE);
               end else begin
                  gen_in   = req.generator;
                  pc_in    = req.parent_conductor;
                  pm_in    = req.parent_multiplicity;
                  psize_in = {1'b0, req.parent_conductor} + {1'b0, req.parent_multiplicity};
                  state_in = nsc_pkg::ST_CHECK;
               end
            end
         end

         nsc_pkg::ST_CHECK: begin
            if (gen_bad) begin
               err_in   = nsc_pkg::STATUS_BAD_GEN;
               state_in = nsc_pkg::ST_ERR;
            end else if (csize_calc > ELIMIT) begin
               err_in   = nsc_pkg::STATUS_OVERFLOW;
               state_in = nsc_pkg::ST_ERR;
            end else begin
               cc_in       = cc_calc;
               cm_in       = cm_calc;
               csize_in    = csize_calc[CW-1:0];
               children_in = '0;
               idx_in      = '0;
               state_in    = nsc_pkg::ST_COPY_RD;
            end
         end

         nsc_pkg::ST_ERR: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = err_ff;
               state_in      = nsc_pkg::ST_IDLE;
            end
         end

         nsc_pkg::ST_COPY_RD: begin
            state_in = nsc_pkg::ST_COPY_WR;
         end

         nsc_pkg::ST_COPY_WR: begin
            chd_wr.en   = 1'b1;
            chd_wr.data = par_rdata_ff;
            if (idx_inc == gen_ext) begin
               state_in = nsc_pkg::ST_GAP;
            end else begin
               idx_in   = idx_inc[IW-1:0];
               state_in = nsc_pkg::ST_COPY_RD;
            end
         end

         nsc_pkg::ST_GAP: begin
            chd_wr.en   = 1'b1;
            chd_wr.addr = gen_ff;
            chd_wr.data = nsc_pkg::ENT_GAP;
            idx_in      = cc_calc[IW-1:0];
            state_in    = nsc_pkg::ST_PAR_RD;
         end

         nsc_pkg::ST_PAR_RD: begin
            state_in = nsc_pkg::ST_PAR_CHK;
         end

         nsc_pkg::ST_PAR_CHK: begin
            if (par_val == nsc_pkg::ENT_IRR) begin
               chd_wr.en   = 1'b1;
               chd_wr.data = nsc_pkg::ENT_IRR;
               children_in = children_ff + CW'(1);
               if (adv_last) begin
                  idx_in   = '0;
                  state_in = nsc_pkg::ST_EMIT_RD;
               end else begin
                  idx_in   = idx_inc[IW-1:0];
                  state_in = nsc_pkg::ST_PAR_RD;
               end
            end else begin
               // Position zero takes part as well: when it is marked
               // irreducible, its partner is the entry under test itself.
               j_in          = '0;
               issue_done_in = 1'b0;
               state_in      = nsc_pkg::ST_SCAN;
            end
         end

         nsc_pkg::ST_SCAN: begin
            // Probe pairs (j, i-j): i is decomposable when j is irreducible
            // and i-j is no gap. One pair is issued per cycle and checked
            // on the next, once the registered read data has arrived.
            chd_addr_a = j_ff;
            chd_addr_b = idx_ff - j_ff;
            if (!issue_done_ff) begin
               probe_vld_in  = 1'b1;
               probe_last_in = (j_ff == idx_ff - IW'(1));
               if (j_ff == idx_ff - IW'(1)) begin
                  issue_done_in = 1'b1;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
            if (probe_vld_ff && (hit || probe_last_ff)) begin
               probe_vld_in = 1'b0;
               chd_wr.en    = 1'b1;
               if (hit) begin
                  chd_wr.data = nsc_pkg::ENT_DEC;
               end else begin
                  chd_wr.data = nsc_pkg::ENT_IRR;
                  children_in = children_ff + CW'(1);
               end
               if (adv_last) begin
                  idx_in   = '0;
                  state_in = nsc_pkg::ST_EMIT_RD;
               end else begin
                  idx_in   = idx_inc[IW-1:0];
                  state_in = nsc_pkg::ST_PAR_RD;
               end
            end
         end

         nsc_pkg::ST_EMIT_RD: begin
            state_in = nsc_pkg::ST_EMIT;
         end

         nsc_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_index_in = idx_ff;
               rsp_value_in = chd_rd_a;
               rsp_last_in  = adv_last;
               if (adv_last) begin
                  rsp_cc_in = cc_ff;
                  rsp_cm_in = cm_ff;
                  rsp_ch_in = children_ff;
                  state_in  = nsc_pkg::ST_IDLE;
               end else begin
                  idx_in    = idx_inc[IW-1:0];
                  state_in  = nsc_pkg::ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = nsc_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nsc_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         probe_vld_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         probe_vld_ff  <= probe_vld_in;
         issue_done_ff <= issue_done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      probe_last_ff <= probe_last_in;
      gen_ff        <= gen_in;
      pc_ff         <= pc_in;
      pm_ff         <= pm_in;
      psize_ff      <= psize_in;
      cc_ff         <= cc_in;
      cm_ff         <= cm_in;
      csize_ff      <= csize_in;
      children_ff   <= children_in;
      err_ff        <= err_in;
      if (rsp_load) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_cc_ff     <= rsp_cc_in;
         rsp_cm_ff     <= rsp_cm_in;
         rsp_ch_ff     <= rsp_ch_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.out_index          = rsp_index_ff;
   assign rsp.out_value          = rsp_value_ff;
   assign rsp.last_entry         = rsp_last_ff;
   assign rsp.child_conductor    = rsp_cc_ff;
   assign rsp.child_multiplicity = rsp_cm_ff;
   assign rsp.child_children     = rsp_ch_ff;
   assign rsp.status             = rsp_status_ff;

   // Only entries past the removed generator are ever rechecked.
   a_scan_past_gen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nsc_pkg::ST_SCAN) |-> (idx_ff > gen_ff))
      else $error("probe loop running on an entry below the generator");

   // Probes only look at entries already settled.
   a_probe_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nsc_pkg::ST_SCAN && !issue_done_ff) |-> (j_ff < idx_ff))
      else $error("probe address reaches the entry being decided");

   // An error result always closes its request.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != nsc_pkg::STATUS_OK) |-> rsp.last_entry)
      else $error("error result not marked last");

   // Summary fields are carried on the last entry only.
   a_mid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.last_entry) |->
         (rsp.child_conductor == '0 && rsp.child_multiplicity == '0 &&
          rsp.child_children == '0))
      else $error("summary fields set on an inner entry");

endmodule

FILE: dv/nsc_child_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_child_checker: predicts and checks the child tables of the generator
// Keeps its own image of the parent table from the loads it sees, builds the
// child that each accepted generate request should produce and compares every
// result leaving the block with the oldest child entry still owed.
// ----------------------------------------------------------------------------
module nsc_child_checker
   import nsc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   nsc_req_if   req_bus,
   nsc_rsp_if   rsp_bus,
   input  logic drain,
   output int   fail_count
);

   typedef struct packed {
      logic [IDX_W-1:0] position;
      nsc_entry_type    value;
      logic             last;
      logic [CNT_W-1:0] conductor;
      logic [CNT_W-1:0] multiplicity;
      logic [CNT_W-1:0] children;
      nsc_status_type   status;
   } child_entry_type;

   nsc_entry_type   parent_image [TABLE_SIZE];
   nsc_entry_type   child_image [TABLE_SIZE];
   int              irr_found [TABLE_SIZE];
   child_entry_type child_stream [$];
   int              mismatches = 0;
   bit              drain_seen = 1'b0;

   assign fail_count = mismatches;

   // Positions at or past the parent size belong to the semigroup.
   function automatic nsc_entry_type parent_entry(int pos, int psize);
      if (pos >= psize || pos >= TABLE_SIZE) return ENT_DEC;
      return parent_image[pos];
   endfunction

   function automatic string describe(child_entry_type e);
      return $sformatf("pos %0d val %0d last %0b cond %0d mult %0d kids %0d status %0d",
                       e.position, e.value, e.last, e.conductor, e.multiplicity,
                       e.children, e.status);
   endfunction

   function automatic void note_failure(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, what);
   endfunction

   task automatic predict_child(input logic [IDX_W-1:0] pc, input logic [IDX_W-1:0] pm,
                                input logic [IDX_W-1:0] gen);
      int              psize;
      int              x;
      int              cc;
      int              cm;
      int              csize;
      int              nirr;
      int              kids;
      bit              irr;
      nsc_entry_type   v;
      child_entry_type r;
      x     = int'(gen);
      psize = int'(pc) + int'(pm);
      r      = '0;
      r.last = 1'b1;
      if (x == 0 || gen < pc || parent_entry(x, psize) != ENT_IRR) begin
         r.status = STATUS_BAD_GEN;
         child_stream.push_back(r);
         return;
      end
      cc    = x + 1;
      cm    = (gen == pm) ? int'(pm) + 1 : int'(pm);
      csize = cc + cm;
      if (csize > EMIT_LIMIT) begin
         r.status = STATUS_OVERFLOW;
         child_stream.push_back(r);
         return;
      end
      nirr = 0;
      for (int i = 0; i < x; i++) begin
         v              = parent_entry(i, psize);
         child_image[i] = v;
         if (v == ENT_IRR) begin
            irr_found[nirr] = i;
            nirr++;
         end
      end
      child_image[x] = ENT_GAP;
      // Past the removed generator an entry is irreducible unless it is an
      // irreducible found so far plus a non-gap of the child.
      for (int i = x + 1; i < csize; i++) begin
         irr = 1'b1;
         if (parent_entry(i, psize) != ENT_IRR) begin
            for (int j = 0; j < nirr; j++)
               if (child_image[i - irr_found[j]] != ENT_GAP) irr = 1'b0;
         end
         child_image[i] = irr ? ENT_IRR : ENT_DEC;
         if (irr) begin
            irr_found[nirr] = i;
            nirr++;
         end
      end
      kids = 0;
      for (int i = cc; i < csize; i++)
         if (child_image[i] == ENT_IRR) kids++;
      for (int k = 0; k < csize; k++) begin
         r          = '0;
         r.position = IDX_W'(k);
         r.value    = child_image[k];
         if (k == csize - 1) begin
            r.last         = 1'b1;
            r.conductor    = CNT_W'(cc);
            r.multiplicity = CNT_W'(cm);
            r.children     = CNT_W'(kids);
         end
         child_stream.push_back(r);
      end
   endtask

   always @(posedge clock) begin : watch
      child_entry_type got;
      child_entry_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.kind == KIND_LOAD) begin
               if (int'(req_bus.table_index) < TABLE_SIZE)
                  parent_image[req_bus.table_index] =
                     (req_bus.entry_value == ENT_ILL) ? ENT_DEC : req_bus.entry_value;
            end else begin
               predict_child(req_bus.parent_conductor, req_bus.parent_multiplicity,
                             req_bus.generator);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{position:     rsp_bus.out_index,
                    value:        rsp_bus.out_value,
                    last:         rsp_bus.last_entry,
                    conductor:    rsp_bus.child_conductor,
                    multiplicity: rsp_bus.child_multiplicity,
                    children:     rsp_bus.child_children,
                    status:       rsp_bus.status};
            if (child_stream.size() == 0) begin
               note_failure({"result with nothing owed: ", describe(got)});
            end else begin
               want = child_stream.pop_front();
               if (got.position !== want.position || got.value !== want.value ||
                   got.last !== want.last || got.conductor !== want.conductor ||
                   got.multiplicity !== want.multiplicity ||
                   got.children !== want.children || got.status !== want.status)
                  note_failure({"expected ", describe(want), " got ", describe(got)});
            end
         end
      end
      if (drain && !drain_seen) begin
         drain_seen = 1'b1;
         if (child_stream.size() != 0)
            note_failure($sformatf("%0d child entries never arrived", child_stream.size()));
      end
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the semigroup child generator test
// Walks random paths down the semigroup tree, loading each parent and asking
// for one of its children, mixed with arbitrary loads and generate requests.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import nsc_pkg::*;

   localparam int     REQUEST_TARGET = 160;
   localparam int     CALM_TAIL      = 30;
   localparam longint CYCLE_LIMIT    = 4_000_000;

   logic   clock;
   logic   reset;
   logic   drain;
   int     fail_count;
   logic   jitter_on   = 1'b0;
   int     ready_hold  = 0;
   longint cycle_count = 0;

   // The semigroup being walked and what the block's parent table holds.
   nsc_entry_type walk_tab [TABLE_SIZE];
   nsc_entry_type loaded_tab [TABLE_SIZE];
   int            walk_pc;
   int            walk_pm;
   int            requests_sent = 0;
   int            loads_sent    = 0;

   // What the result channel has delivered.
   nsc_entry_type    child_seen [TABLE_SIZE];
   logic [CNT_W-1:0] seen_cc;
   logic [CNT_W-1:0] seen_cm;
   nsc_status_type   seen_status;
   int               gens_accepted = 0;
   int               lasts_seen    = 0;
   int               entries_seen  = 0;
   int               bad_gen_seen  = 0;
   int               overflow_seen = 0;

   nsc_req_if req_bus ();
   nsc_rsp_if rsp_bus ();

   numerical_semigroup_child dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   nsc_child_checker child_check (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .drain     (drain),
      .fail_count(fail_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("** numerical_semigroup_child: FAILED **");
         $finish;
      end
      if (!reset && req_bus.valid && req_bus.ready && req_bus.kind == KIND_GEN)
         gens_accepted <= gens_accepted + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         child_seen[rsp_bus.out_index] <= rsp_bus.out_value;
         if (rsp_bus.status == STATUS_OK) entries_seen <= entries_seen + 1;
         if (rsp_bus.status == STATUS_BAD_GEN) bad_gen_seen <= bad_gen_seen + 1;
         if (rsp_bus.status == STATUS_OVERFLOW) overflow_seen <= overflow_seen + 1;
         if (rsp_bus.last_entry) begin
            lasts_seen  <= lasts_seen + 1;
            seen_status <= rsp_bus.status;
            seen_cc     <= rsp_bus.child_conductor;
            seen_cm     <= rsp_bus.child_multiplicity;
         end
      end
      // Receiver stalls come in bursts.
      if (ready_hold > 0) begin
         ready_hold    <= ready_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (jitter_on && !reset && $urandom_range(0, 7) == 0) begin
         ready_hold    <= $urandom_range(1, 17) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic kind, input int idx, input int val,
                               input int pc, input int pm, input int gen);
      if (jitter_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.kind                <= kind;
      req_bus.table_index         <= IDX_W'(idx);
      req_bus.entry_value         <= 2'(val);
      req_bus.parent_conductor    <= IDX_W'(pc);
      req_bus.parent_multiplicity <= IDX_W'(pm);
      req_bus.generator           <= IDX_W'(gen);
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      requests_sent++;
      if (kind == KIND_LOAD) begin
         loaded_tab[IDX_W'(idx)] = (2'(val) == ENT_ILL) ? ENT_DEC : nsc_entry_type'(val);
         loads_sent++;
      end
   endtask

   task automatic load_entry(input int idx, input int val);
      send_request(KIND_LOAD, idx, val, $urandom_range(1, 63), $urandom_range(1, 63),
                   $urandom_range(0, 63));
   endtask

   task automatic generate_child(input int pc, input int pm, input int gen);
      send_request(KIND_GEN, $urandom_range(0, 63), $urandom_range(0, 3), pc, pm, gen);
   endtask

   // Holds the request side quiet until every generate has had its last result.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (gens_accepted != lasts_seen) @(posedge clock);
   endtask

   // The tree's root: every positive integer, with 1 its only generator.
   task automatic restart_at_root();
      foreach (walk_tab[i]) walk_tab[i] = ENT_DEC;
      walk_tab[1] = ENT_IRR;
      walk_pc     = 1;
      walk_pm     = 1;
   endtask

   initial begin
      int            picks [$];
      int            psize;
      int            x;
      int            cm;
      int            csize;
      nsc_entry_type v;
      clock = 1'b0;
      reset <= 1'b1;
      drain <= 1'b0;
      req_bus.valid               <= 1'b0;
      req_bus.kind                <= KIND_LOAD;
      req_bus.table_index         <= '0;
      req_bus.entry_value         <= ENT_GAP;
      req_bus.parent_conductor    <= '0;
      req_bus.parent_multiplicity <= '0;
      req_bus.generator           <= '0;
      // An illegal code marks entries the block has never been given.
      foreach (loaded_tab[i]) loaded_tab[i] = ENT_ILL;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      jitter_on = 1'b1;

      // Directed part: small tables, every error path and the field extremes.
      load_entry(0, int'(ENT_ILL));
      load_entry(1, int'(ENT_IRR));
      load_entry(2, int'(ENT_DEC));
      load_entry(3, int'(ENT_DEC));
      load_entry(63, int'(ENT_IRR));
      generate_child(1, 1, 1);
      generate_child(1, 1, 0);
      generate_child(2, 1, 1);
      generate_child(1, 1, 2);
      generate_child(1, 3, 2);
      generate_child(63, 1, 63);
      generate_child(1, 63, 63);
      load_entry(2, int'(ENT_GAP));
      generate_child(1, 2, 1);

      // Every entry gets written once, so arbitrary requests never read junk.
      for (int i = 0; i < TABLE_SIZE; i++) load_entry(i, $urandom_range(0, 3));
      restart_at_root();

      while (requests_sent < REQUEST_TARGET) begin
         if (requests_sent >= REQUEST_TARGET - CALM_TAIL) jitter_on = 1'b0;
         else if ($urandom_range(0, 7) == 0) jitter_on = ~jitter_on;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0) begin
                  load_entry($urandom_range(0, 63), $urandom_range(0, 3));
               end else begin
                  psize = $urandom_range(1, 63);
                  generate_child(psize, $urandom_range(1, 63),
                                 $urandom_range(0, 1) ? $urandom_range(psize, 63)
                                                      : $urandom_range(0, 63));
               end
            end
         end else begin
            if ($urandom_range(0, 24) == 0) restart_at_root();
            psize = walk_pc + walk_pm;
            picks.delete();
            for (int g = walk_pc; g < psize && g < TABLE_SIZE; g++) begin
               cm = (g == walk_pm) ? walk_pm + 1 : walk_pm;
               if (walk_tab[g] == ENT_IRR && g + 1 + cm <= EMIT_LIMIT) picks.push_back(g);
            end
            if (picks.size() == 0) begin
               restart_at_root();
               psize = walk_pc + walk_pm;
               picks.push_back(1);
            end
            for (int i = 0; i < psize && i < TABLE_SIZE; i++) begin
               if (loaded_tab[i] != walk_tab[i]) begin
                  v = walk_tab[i];
                  if (v == ENT_DEC && $urandom_range(0, 3) == 0) v = ENT_ILL;
                  load_entry(i, int'(v));
               end
            end
            // Now and then a parent entry is spoilt before the request.
            if ($urandom_range(0, 11) == 0)
               load_entry($urandom_range(0, psize - 1), $urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 63);
            else x = picks[$urandom_range(0, picks.size() - 1)];
            generate_child(walk_pc, walk_pm, x);
            wait_for_results();
            if (seen_status == STATUS_OK) begin
               csize = int'(seen_cc) + int'(seen_cm);
               for (int i = 0; i < csize; i++) walk_tab[i] = child_seen[i];
               walk_pc = int'(seen_cc);
               walk_pm = int'(seen_cm);
            end
         end
      end

      jitter_on = 1'b0;
      wait_for_results();
      repeat (20) @(posedge clock);
      drain <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Run covered %0d requests (%0d loads, %0d generates), %0d child entries,",
               requests_sent, loads_sent, gens_accepted, entries_seen);
      $display("%0d invalid-generator and %0d overflow results.", bad_gen_seen, overflow_seen);
      if (fail_count == 0) begin
         $display("** numerical_semigroup_child: PASSED **");
      end else begin
         $display("** numerical_semigroup_child: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/nsc_pkg.sv
rtl/nsc_req_if.sv
rtl/nsc_rsp_if.sv
rtl/nsc_child_mem.sv
rtl/numerical_semigroup_child.sv
dv/nsc_child_checker.sv
dv/testbench.sv
